### rtl/vaur_pkg.sv
`default_nettype none
package vaur_pkg;
    localparam int CordicSteps = 20;
    localparam int FracBits = 16;
    localparam int Prescale = 24;
    localparam int StepW = 5;
    localparam int CordW = 44;
    localparam int ZW = 40;

    typedef enum logic [2:0] {
        t_ANG_IDLE, t_ANG_RUN, t_ANG_FIX, t_ANG_DONE
    } t_ang_state;

    typedef enum logic [1:0] {
        t_DIV_IDLE, t_DIV_RUN, t_DIV_DONE
    } t_div_state;

    // front queue entry
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        t;
    } t_sample;

    function automatic logic signed [ZW-1:0] atan_deg(input logic [StepW-1:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = 40'sd193273528320;
                5'd1:  r = 40'sd114096026022;
                5'd2:  r = 40'sd60285206653;
                5'd3:  r = 40'sd30601712202;
                5'd4:  r = 40'sd15360239180;
                5'd5:  r = 40'sd7687607525;
                5'd6:  r = 40'sd3844741810;
                5'd7:  r = 40'sd1922488225;
                5'd8:  r = 40'sd961258780;
                5'd9:  r = 40'sd480631223;
                5'd10: r = 40'sd240315841;
                5'd11: r = 40'sd120157949;
                5'd12: r = 40'sd60078978;
                5'd13: r = 40'sd30039490;
                5'd14: r = 40'sd15019745;
                5'd15: r = 40'sd7509872;
                5'd16: r = 40'sd3754936;
                5'd17: r = 40'sd1877468;
                5'd18: r = 40'sd938734;
                5'd19: r = 40'sd469367;
                5'd20: r = 40'sd234684;
                5'd21: r = 40'sd117342;
                5'd22: r = 40'sd58671;
                5'd23: r = 40'sd29335;
                5'd24: r = 40'sd14668;
                5'd25: r = 40'sd7334;
                5'd26: r = 40'sd3667;
                5'd27: r = 40'sd1833;
                5'd28: r = 40'sd917;
                5'd29: r = 40'sd458;
                5'd30: r = 40'sd229;
                default: r = 40'sd115;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

### rtl/vector_angle_unwrap_rate_core.sv
`default_nettype none
// vector_angle_unwrap_rate_core
// Input channel: i_valid / o_stall carry one magnetometer sample (x, y, time).
// Output channel: o_valid / i_stall carry raw angle, total angle, turn rate
// and the zero-interval flag, one result item per sample.
// A two-entry queue holds accepted samples while the back end works.
// The back end runs one item at a time: a CORDIC load step, the iteration
// steps (fewer when x is zero), a quadrant fix-up, a fold and launch step, a
// divider load, a bit-serial divider and a result register; the next queued
// item can start in the cycle after the result is taken; the divider and
// CORDIC iteration loops take most of the time per item.
// Reset (synchronous, active low) clears the queue, the last angle, the
// total angle and the last timestamp to zero.
// When the receiver stalls, the result is held and the back end waits;
// the front queue keeps taking up to two samples, then stalls the sender.
module vector_angle_unwrap_rate_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_x_reading,
    input  wire logic [15:0] i_y_reading,
    input  wire logic [31:0] i_time_us,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [24:0]      o_raw_angle,
    output logic [31:0]      o_total_angle,
    output logic [24:0]      o_turn_rate,
    output logic             o_zero_interval
);
    import vaur_pkg::*;

    t_sample w_q;
    logic    w_qv, w_pop;
    logic    w_abusy, w_adone, w_ddone, w_ack;
    logic [24:0] w_angle, w_quot;
    logic [31:0] r_last_ang, r_acc, r_last_t, r_elapsed;
    logic signed [31:0] r_delta;
    logic    r_dstart, r_zero, r_indiv, r_out_v;
    logic signed [31:0] w_d0, w_fold;
    logic [31:0] w_mag;

    vaur_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_x_reading, .i_y_reading, .i_time_us,
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_data(w_q)
    );

    // start angle when back end is free
    assign w_pop = w_qv && !w_abusy && !r_indiv && !r_out_v;

    vaur_angle u_angle (
        .i_clk, .i_rst_n, .i_start(w_pop), .i_x(w_q.x), .i_y(w_q.y),
        .o_busy(w_abusy), .o_done(w_adone), .o_angle(w_angle), .i_ack(w_ack)
    );

    vaur_div u_div (
        .i_clk, .i_rst_n, .i_start(r_dstart), .i_num(r_delta), .i_den(r_elapsed),
        .o_done(w_ddone), .o_quot(w_quot), .i_ack(w_ack)
    );

    // unwrap of the angle change
    assign w_d0  = $signed({7'd0, w_angle}) - $signed(r_last_ang);
    assign w_mag = w_d0[31] ? 32'(-w_d0) : 32'(w_d0);
    always_comb begin
        w_fold = w_d0;
        if (w_mag >= (32'd180 << FracBits))
            w_fold = w_d0[31] ? w_d0 + (32'sd360 <<< FracBits)
                              : w_d0 - (32'sd360 <<< FracBits);
    end

    assign w_ack = !r_out_v && w_adone && w_ddone;
    assign o_valid = r_out_v;
    assign o_zero_interval = r_zero;
    assign o_total_angle = r_acc;

    always_ff @(posedge i_clk) begin
        if (w_pop) r_elapsed <= w_q.t - r_last_t;
        if (!i_rst_n) begin
            r_last_ang <= '0; r_acc <= '0; r_last_t <= '0;
            r_dstart <= 1'b0; r_indiv <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r_dstart <= w_adone && !r_indiv && !r_out_v;
            if (w_pop) r_last_t <= w_q.t;
            // angle ready: update state, launch divide
            if (w_adone && !r_indiv && !r_out_v) begin
                r_last_ang <= {7'd0, w_angle};
                r_acc <= r_acc + w_fold;
                r_delta <= w_fold;
                r_zero <= (r_elapsed == 32'd0);
                r_indiv <= 1'b1;
                o_raw_angle <= w_angle;
            end
            if (w_ack) begin
                r_indiv <= 1'b0;
                r_out_v <= 1'b1;
                o_turn_rate <= r_zero ? 25'd0 : w_quot;
            end
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### rtl/vaur_front.sv
`default_nettype none
module vaur_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [15:0]      i_x_reading,
    input  wire logic [15:0]      i_y_reading,
    input  wire logic [31:0]      i_time_us,
    output logic                  o_q_valid,
    input  wire logic             i_q_pop,
    output vaur_pkg::t_sample     o_q_data
);
    import vaur_pkg::*;

    t_sample     r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rp];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{x: i_x_reading, y: i_y_reading, t: i_time_us};
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

### rtl/vaur_angle.sv
`default_nettype none
module vaur_angle (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [15:0]      i_x,
    input  wire logic [15:0]      i_y,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [24:0]           o_angle,
    input  wire logic             i_ack
);
    import vaur_pkg::*;

    t_ang_state r_state, n_state;
    logic signed [CordW-1:0] r_px, r_py;
    logic signed [ZW-1:0]    r_z;
    logic [StepW-1:0]        r_i;
    logic                    r_xneg, r_yneg, r_xzero, r_yzero, r_ypos;
    logic [24:0]             r_angle;
    logic signed [CordW-1:0] w_dx, w_dy;
    logic signed [ZW-1:0]    w_q;
    logic signed [ZW+1:0]    w_a;
    logic [16:0]             w_ax, w_ay;

    assign w_ax = i_x[15] ? 17'(-$signed({i_x[15], i_x})) : {1'b0, i_x};
    assign w_ay = i_y[15] ? 17'(-$signed({i_y[15], i_y})) : {1'b0, i_y};
    assign w_dx = r_py >>> r_i;
    assign w_dy = r_px >>> r_i;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            t_ANG_IDLE: if (i_start) n_state = t_ANG_RUN;
            t_ANG_RUN:  if (r_xzero || r_i == StepW'(CordicSteps - 1)) n_state = t_ANG_FIX;
            t_ANG_FIX:  n_state = t_ANG_DONE;
            t_ANG_DONE: if (i_ack) n_state = t_ANG_IDLE;
            default:    n_state = t_ANG_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != t_ANG_IDLE);
        o_done = (r_state == t_ANG_DONE);
        o_angle = r_angle;
    end

    // quadrant mapping of clamped angle
    always_comb begin
        w_q = r_z;
        if (r_z < 0) w_q = '0;
        if (r_z > (ZW'(90) <<< 32)) w_q = ZW'(90) <<< 32;
        if (!r_xneg) w_a = r_yneg ? ((42'sd360 <<< 32) - w_q) : 42'(w_q);
        else w_a = r_yneg ? ((42'sd180 <<< 32) + w_q) : ((42'sd180 <<< 32) - w_q);
        w_a = w_a + (42'sd1 <<< (31 - FracBits));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ANG_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            t_ANG_IDLE: begin
                r_xneg  <= i_x[15];
                r_yneg  <= i_y[15];
                r_xzero <= (i_x == 16'd0);
                r_yzero <= (i_y == 16'd0);
                r_ypos  <= !i_y[15] && (i_y != 16'd0);
                r_px <= CordW'(w_ax) <<< Prescale;
                r_py <= CordW'(w_ay) <<< Prescale;
                r_z  <= '0;
                r_i  <= '0;
            end
            t_ANG_RUN: begin
                if (r_py > 0) begin
                    r_px <= r_px + w_dx;
                    r_py <= r_py - w_dy;
                    r_z  <= r_z + atan_deg(r_i);
                end else begin
                    r_px <= r_px - w_dx;
                    r_py <= r_py + w_dy;
                    r_z  <= r_z - atan_deg(r_i);
                end
                r_i <= r_i + 1'b1;
            end
            t_ANG_FIX: begin
                if (r_xzero) begin
                    if (r_ypos) r_angle <= 25'(90) << FracBits;
                    else if (r_yzero) r_angle <= '0;
                    else r_angle <= 25'(270) << FracBits;
                end else begin
                    r_angle <= w_a[24 + 32 - FracBits : 32 - FracBits];
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### rtl/vaur_div.sv
`default_nettype none
module vaur_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic [31:0]  i_den,
    output logic              o_done,
    output logic [24:0]       o_quot,
    input  wire logic         i_ack
);
    import vaur_pkg::*;

    t_div_state r_state, n_state;
    logic [31:0] r_q, r_d;
    logic [32:0] r_r;
    logic        r_neg;
    logic [5:0]  r_n;
    logic [32:0] w_rs;
    logic [31:0] w_mag;

    assign w_rs  = {r_r[31:0], r_q[31]};
    assign w_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            t_DIV_IDLE: if (i_start) n_state = t_DIV_RUN;
            t_DIV_RUN:  if (r_n == 6'd31) n_state = t_DIV_DONE;
            t_DIV_DONE: if (i_ack) n_state = t_DIV_IDLE;
            default:    n_state = t_DIV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_state == t_DIV_DONE);
        o_quot = r_neg ? 25'(-r_q) : r_q[24:0];
    end

    // restoring divide, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_DIV_IDLE;
        else r_state <= n_state;
        case (r_state)
            t_DIV_IDLE: begin
                r_q <= w_mag; r_d <= i_den; r_r <= '0;
                r_neg <= i_num[31]; r_n <= '0;
            end
            t_DIV_RUN: begin
                if (w_rs >= {1'b0, r_d}) begin
                    r_r <= w_rs - {1'b0, r_d};
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_r <= w_rs;
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_n <= r_n + 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import vaur_pkg::*;

    // one expected result item
    typedef struct {
        logic [24:0] raw;
        logic [31:0] total;
        logic [24:0] rate;
        logic        zint;
    } t_heading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_x_reading;
    logic [15:0] i_y_reading;
    logic [31:0] i_time_us;
    logic        o_valid;
    logic        i_stall;
    logic [24:0] o_raw_angle;
    logic [31:0] o_total_angle;
    logic [24:0] o_turn_rate;
    logic        o_zero_interval;

    vector_angle_unwrap_rate_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_x_reading(i_x_reading), .i_y_reading(i_y_reading), .i_time_us(i_time_us),
        .o_valid(o_valid), .i_stall(i_stall), .o_raw_angle(o_raw_angle),
        .o_total_angle(o_total_angle), .o_turn_rate(o_turn_rate),
        .o_zero_interval(o_zero_interval)
    );

    // predictor state
    logic [31:0] prev_angle;
    logic [31:0] heading_sum;
    logic [31:0] prev_stamp;
    t_heading    pending_headings[$];
    int          n_errors;
    int          n_checked;
    int          n_sent;
    int          hold_off;
    logic [31:0] stamp;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // arctangent table in degrees Q32
    function automatic longint atan_q32(input int i);
        longint tbl[32] = '{
            64'd193273528320, 64'd114096026022, 64'd60285206653, 64'd30601712202,
            64'd15360239180, 64'd7687607525, 64'd3844741810, 64'd1922488225,
            64'd961258780, 64'd480631223, 64'd240315841, 64'd120157949,
            64'd60078978, 64'd30039490, 64'd15019745, 64'd7509872,
            64'd3754936, 64'd1877468, 64'd938734, 64'd469367,
            64'd234684, 64'd117342, 64'd58671, 64'd29335,
            64'd14668, 64'd7334, 64'd3667, 64'd1833,
            64'd917, 64'd458, 64'd229, 64'd115};
        return tbl[i];
    endfunction

    // vector angle in degrees Q.16
    function automatic logic [31:0] heading_of(input int x, input int y);
        longint px, py, z, dx, dy, q, a;
        px = longint'(x < 0 ? -x : x) <<< Prescale;
        py = longint'(y < 0 ? -y : y) <<< Prescale;
        z = 0;
        if (x == 0) begin
            if (y > 0) return 32'(90) << FracBits;
            if (y < 0) return 32'(270) << FracBits;
            return 32'd0;
        end
        for (int i = 0; i < CordicSteps; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (py > 0) begin
                px += dx; py -= dy; z += atan_q32(i);
            end else begin
                px -= dx; py += dy; z -= atan_q32(i);
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) <<< 32)) z = longint'(90) <<< 32;
        q = z;
        if (x > 0) a = (y >= 0) ? q : (longint'(360) <<< 32) - q;
        else a = (y >= 0) ? (longint'(180) <<< 32) - q : (longint'(180) <<< 32) + q;
        a += longint'(1) <<< (31 - FracBits);
        return 32'(a >>> (32 - FracBits));
    endfunction

    // advance the predictor by one sample
    function automatic void predict_heading(input logic [15:0] x, input logic [15:0] y,
                                            input logic [31:0] t);
        t_heading    h;
        logic [31:0] ang, gap;
        longint      delta, mag, rate;
        ang = heading_of(int'($signed(x)), int'($signed(y)));
        gap = t - prev_stamp;
        delta = longint'(ang) - longint'(prev_angle);
        mag = delta < 0 ? -delta : delta;
        if (mag >= (longint'(180) <<< FracBits))
            delta = delta > 0 ? delta - (longint'(360) <<< FracBits)
                              : delta + (longint'(360) <<< FracBits);
        prev_stamp = t;
        prev_angle = ang;
        heading_sum = heading_sum + 32'(delta);
        rate = (gap == 0) ? 0 : delta / longint'(gap);
        h.raw = ang[24:0];
        h.total = heading_sum;
        h.rate = rate[24:0];
        h.zint = (gap == 0);
        pending_headings.push_back(h);
    endfunction

    // send one sample, waiting for acceptance; valid stays up for the next one
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [31:0] t);
        i_valid <= 1'b1;
        i_x_reading <= x;
        i_y_reading <= y;
        i_time_us <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_heading(x, y, t);
        n_sent++;
    endtask

    task automatic idle_gap(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending_headings.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    // receiver stall pattern, with an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else if ((n_sent / 100) % 3 == 1) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_heading h;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_headings.size() == 0) begin
                $error("unexpected result item raw=%0h", o_raw_angle);
                n_errors++;
            end else begin
                h = pending_headings.pop_front();
                n_checked++;
                if (o_raw_angle !== h.raw) begin
                    $error("raw_angle exp %0h got %0h", h.raw, o_raw_angle);
                    n_errors++;
                end
                if (o_total_angle !== h.total) begin
                    $error("total_angle exp %0h got %0h", h.total, o_total_angle);
                    n_errors++;
                end
                if (o_turn_rate !== h.rate) begin
                    $error("turn_rate exp %0h got %0h", h.rate, o_turn_rate);
                    n_errors++;
                end
                if (o_zero_interval !== h.zint) begin
                    $error("zero_interval exp %0h got %0h", h.zint, o_zero_interval);
                    n_errors++;
                end
            end
        end
    end

    // extremes, axes, zero vector, zero interval, timestamp wrap
    task automatic test_directed();
        send_sample(16'd0, 16'd0, 32'd0);
        send_sample(16'd0, 16'd100, 32'd10);
        send_sample(16'd0, 16'h8000, 32'd10);
        send_sample(16'h7fff, 16'd0, 32'd11);
        send_sample(16'h8000, 16'd0, 32'd500);
        send_sample(16'h7fff, 16'h7fff, 32'd501);
        send_sample(16'h8000, 16'h8000, 32'd600);
        send_sample(16'h8000, 16'h7fff, 32'hffff_fff0);
        send_sample(16'h7fff, 16'h8000, 32'd5);
        send_sample(16'h7fff, 16'hffff, 32'd6);
        send_sample(16'd1, 16'hffff, 32'd6);
        send_sample(16'hffff, 16'd1, 32'hffff_ffff);
        send_sample(16'd1, 16'd0, 32'd0);
        send_sample(16'd1, 16'd1, 32'h8000_0000);
        send_sample(16'hffff, 16'hffff, 32'h8000_0001);
        send_sample(16'h7fff, 16'hffff, 32'h8000_0002);
        send_sample(16'h7fff, 16'd1, 32'h8000_0003);
        drain();
    endtask

    // rotating vectors with random gaps, some noise and jumps
    task automatic test_random(input int n);
        int mag, x, y, cur;
        cur = $urandom_range(0, 359);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) idle_gap($urandom_range(1, 20));
            if ($urandom_range(0, 4) == 0) begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
            end else begin
                cur = (cur + $urandom_range(0, 60) - 30 + 360) % 360;
                mag = $urandom_range(0, 3) == 0 ? $urandom_range(1, 50)
                                                : $urandom_range(100, 32767);
                x = $rtoi(mag * $cos(cur * 3.14159265 / 180.0));
                y = $rtoi(mag * $sin(cur * 3.14159265 / 180.0));
            end
            case ($urandom_range(0, 9))
                0: ;
                1: stamp = stamp + $urandom;
                default: stamp = stamp + $urandom_range(1, 3000);
            endcase
            send_sample(16'(x), 16'(y), stamp);
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_off = 600;
        for (int i = 0; i < 30; i++) begin
            stamp = stamp + $urandom_range(0, 50);
            send_sample(16'($urandom), 16'($urandom), stamp);
        end
        drain();
    endtask

    initial begin
        n_errors = 0; n_checked = 0; n_sent = 0; hold_off = 0;
        prev_angle = 0; heading_sum = 0; prev_stamp = 0; stamp = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_x_reading = '0; i_y_reading = '0; i_time_us = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        test_backpressure();
        test_random(400);
        $display("run covered %0d samples (axes, extremes, wraps, stalls), %0d results checked",
                 n_sent, n_checked);
        if (n_errors == 0 && pending_headings.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end
endmodule

### files.f
rtl/vaur_pkg.sv
rtl/vaur_front.sv
rtl/vaur_angle.sv
rtl/vaur_div.sv
rtl/vector_angle_unwrap_rate_core.sv
tb/tb.sv
